>>> rtl/wavp_pkg.sv
// Shared types and constants for the WAV header chunk parser.
package wavp_pkg;

	localparam int OFFSET_BITS_DEF = 32;

	// Chunk identifiers as they appear big-endian in the byte stream.
	localparam logic [31:0] ID_RIFF = 32'h52494646;
	localparam logic [31:0] ID_WAVE = 32'h57415645;
	localparam logic [31:0] ID_FMT  = 32'h666D7420;
	localparam logic [31:0] ID_CUE  = 32'h63756520;
	localparam logic [31:0] ID_LIST = 32'h4C495354;
	localparam logic [31:0] ID_DATA = 32'h64617461;
	localparam logic [31:0] ID_MARK = 32'h6D61726B;

	localparam int QUO_BITS = 32;
	localparam int DIV_BITS = 13;

	typedef enum logic [1:0] {
		PH_TOP,
		PH_WAVE,
		PH_SUB,
		PH_STOP
	} phase_t;

	typedef enum logic [2:0] {
		RPT_OK,
		RPT_NO_RIFF,
		RPT_NO_FMT,
		RPT_NOT_PCM,
		RPT_NO_DATA,
		RPT_BAD_LOOP,
		RPT_ZERO_WIDTH
	} rpt_status_t;

	typedef enum logic [2:0] {
		S_SCAN,
		S_START,
		S_DIV,
		S_LOAD,
		S_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic byte_en;
		logic div_start;
		logic load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

>>> rtl/wavp_if.sv
// Stream interfaces for file bytes and for the parse report.
interface wavp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface wavp_report_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  status;
	logic        [15:0] channels;
	logic signed [31:0] sample_rate;
	logic        [12:0] sample_width;
	logic signed [31:0] loop_start;
	logic signed [31:0] sample_count;
	logic        [31:0] data_offset;

	modport source (output valid, output status, output channels, output sample_rate,
		output sample_width, output loop_start, output sample_count, output data_offset,
		input ready);
	modport sink (input valid, input status, input channels, input sample_rate,
		input sample_width, input loop_start, input sample_count, input data_offset,
		output ready);
endinterface

>>> rtl/wavp_div.sv
// Restoring divider, one quotient bit per cycle.
module wavp_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [wavp_pkg::QUO_BITS-1:0]    dividend,
	input  logic [wavp_pkg::DIV_BITS-1:0]    divisor,
	output logic [wavp_pkg::QUO_BITS-1:0]    quotient,
	output logic                             done
);
	localparam int CW = $clog2(wavp_pkg::QUO_BITS);

	logic                          busy_q;
	logic [CW-1:0]                 cnt_q;
	logic [wavp_pkg::DIV_BITS-1:0] rem_q;
	logic [wavp_pkg::DIV_BITS-1:0] dvs_q;
	logic [wavp_pkg::QUO_BITS-1:0] quo_q;
	logic [wavp_pkg::DIV_BITS:0]   trial;
	logic                          fits;

	// Shift in the next dividend bit and try the subtraction.
	assign trial = {rem_q, quo_q[wavp_pkg::QUO_BITS-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign done  = busy_q && (cnt_q == CW'(wavp_pkg::QUO_BITS - 1));
	assign quotient = quo_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= wavp_pkg::DIV_BITS'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[wavp_pkg::DIV_BITS-1:0];
			end
			quo_q <= {quo_q[wavp_pkg::QUO_BITS-2:0], fits};
		end
	end
endmodule

>>> rtl/wavp_dpath.sv
// Datapath: chunk walker, field capture, divider and report register.
module wavp_dpath #(
	parameter int OFFSET_BITS = wavp_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wavp_pkg::cmd_t     cmd,
	output wavp_pkg::sts_t     sts,
	input  logic [7:0]         byte_value,
	output logic [2:0]         status,
	output logic [15:0]        channels,
	output logic signed [31:0] sample_rate,
	output logic [12:0]        sample_width,
	output logic signed [31:0] loop_start,
	output logic signed [31:0] sample_count,
	output logic [31:0]        data_offset
);
	localparam int OB = OFFSET_BITS;
	// Wide enough for a header position plus a 31-bit length.
	localparam int NW = ((OB > 31) ? OB : 31) + 2;

	logic [OB:0]            boff_q;
	wavp_pkg::phase_t       phase_q;
	logic [OB-1:0]          cstart_q;
	logic [NW-1:0]          ncoff_q;
	logic [63:0]            hdr_q;
	logic                   f_riff_q, f_fmt_q, f_cue_q, f_list_q, f_data_q;
	logic [63:0]            fmt_q;
	logic [15:0]            fbits_q;
	logic [OB-1:0]          fmt_start_q, cue_start_q, list_start_q, data_start_q;
	logic [31:0]            cue_ls_q, mark_q, loop_len_q, data_len_q;

	logic [OB-1:0]          pos;
	logic                   in_range;
	logic [63:0]            hdr_n;
	logic [31:0]            hid, hlen;
	logic [NW-1:0]          hnext;
	logic                   at_hdr, at_wave;
	logic [OB-1:0]          d_fmt, d_cue, d_list;

	logic [wavp_pkg::QUO_BITS-1:0] quo;
	logic                   div_done;
	logic [12:0]            width;
	logic [31:0]            loop_st, loop_sum;
	wavp_pkg::rpt_status_t  r_status;
	logic [31:0]            r_count, r_doff;
	logic [15:0]            r_chan;
	logic [31:0]            r_rate, r_lst;
	logic [12:0]            r_width;

	// Byte position and header window.
	assign pos      = boff_q[OB-1:0];
	assign in_range = !boff_q[OB];
	assign hdr_n    = {hdr_q[55:0], byte_value};
	assign hid      = hdr_n[63:32];
	assign hlen     = {hdr_n[7:0], hdr_n[15:8], hdr_n[23:16], hdr_n[31:24]};
	assign hnext    = ncoff_q + NW'(8) + (NW'({1'b0, hlen} + 33'd1) & ~NW'(1));
	assign at_hdr   = (phase_q == wavp_pkg::PH_TOP || phase_q == wavp_pkg::PH_SUB)
		&& (NW'(pos) == ncoff_q + NW'(7));
	assign at_wave  = (phase_q == wavp_pkg::PH_WAVE) && (NW'(pos) == NW'(cstart_q) + NW'(11));
	assign d_fmt    = pos - fmt_start_q;
	assign d_cue    = pos - cue_start_q;
	assign d_list   = pos - list_start_q;

	// Walker and capture registers; cleared after each report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boff_q   <= '0;
			phase_q  <= wavp_pkg::PH_TOP;
			cstart_q <= '0;
			ncoff_q  <= '0;
			hdr_q    <= '0;
			f_riff_q <= 1'b0;
			f_fmt_q  <= 1'b0;
			f_cue_q  <= 1'b0;
			f_list_q <= 1'b0;
			f_data_q <= 1'b0;
			fmt_q    <= '0;
			fbits_q  <= '0;
			fmt_start_q  <= '0;
			cue_start_q  <= '0;
			list_start_q <= '0;
			data_start_q <= '0;
			cue_ls_q   <= '0;
			mark_q     <= '0;
			loop_len_q <= '0;
			data_len_q <= '0;
		end else if (cmd.load) begin
			boff_q   <= '0;
			phase_q  <= wavp_pkg::PH_TOP;
			cstart_q <= '0;
			ncoff_q  <= '0;
			hdr_q    <= '0;
			f_riff_q <= 1'b0;
			f_fmt_q  <= 1'b0;
			f_cue_q  <= 1'b0;
			f_list_q <= 1'b0;
			f_data_q <= 1'b0;
			fmt_q    <= '0;
			fbits_q  <= '0;
			fmt_start_q  <= '0;
			cue_start_q  <= '0;
			list_start_q <= '0;
			data_start_q <= '0;
			cue_ls_q   <= '0;
			mark_q     <= '0;
			loop_len_q <= '0;
			data_len_q <= '0;
		end else if (cmd.byte_en && in_range) begin
			boff_q <= boff_q + 1'b1;
			hdr_q  <= hdr_n;
			// Field capture at fixed offsets from each noted chunk.
			if (f_fmt_q) begin
				if (d_fmt >= OB'(8) && d_fmt <= OB'(15)) begin
					fmt_q[8*(d_fmt[2:0]) +: 8] <= byte_value;
				end else if (d_fmt == OB'(22)) begin
					fbits_q[7:0] <= byte_value;
				end else if (d_fmt == OB'(23)) begin
					fbits_q[15:8] <= byte_value;
				end
			end
			if (f_cue_q && d_cue >= OB'(32) && d_cue <= OB'(35)) begin
				cue_ls_q[8*(d_cue[1:0]) +: 8] <= byte_value;
			end
			if (f_list_q) begin
				if (d_list >= OB'(24) && d_list <= OB'(27)) begin
					loop_len_q[8*(d_list[1:0]) +: 8] <= byte_value;
				end else if (d_list >= OB'(28) && d_list <= OB'(31)) begin
					mark_q <= {mark_q[23:0], byte_value};
				end
			end
			// Chunk header handling.
			if (at_hdr) begin
				if (hlen[31]) begin
					phase_q <= wavp_pkg::PH_STOP;
				end else if (phase_q == wavp_pkg::PH_TOP && hid == wavp_pkg::ID_RIFF) begin
					cstart_q <= ncoff_q[OB-1:0];
					phase_q  <= wavp_pkg::PH_WAVE;
				end else begin
					ncoff_q <= hnext;
					if (phase_q == wavp_pkg::PH_SUB) begin
						if (hid == wavp_pkg::ID_FMT && !f_fmt_q) begin
							f_fmt_q     <= 1'b1;
							fmt_start_q <= ncoff_q[OB-1:0];
						end else if (hid == wavp_pkg::ID_CUE && !f_cue_q) begin
							f_cue_q     <= 1'b1;
							cue_start_q <= ncoff_q[OB-1:0];
						end else if (hid == wavp_pkg::ID_LIST && f_cue_q && !f_list_q) begin
							f_list_q     <= 1'b1;
							list_start_q <= ncoff_q[OB-1:0];
						end
						if (hid == wavp_pkg::ID_DATA && !f_data_q) begin
							f_data_q     <= 1'b1;
							data_start_q <= ncoff_q[OB-1:0];
							data_len_q   <= hlen;
						end
					end
				end
			end else if (at_wave) begin
				if (hdr_n[31:0] == wavp_pkg::ID_WAVE) begin
					f_riff_q <= 1'b1;
					phase_q  <= wavp_pkg::PH_SUB;
					ncoff_q  <= NW'(cstart_q) + NW'(12);
				end else begin
					phase_q <= wavp_pkg::PH_STOP;
				end
			end
		end
	end

	// Data samples = data length / bytes per sample.
	assign width = fbits_q[15:3];

	wavp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (data_len_q),
		.divisor  (width),
		.quotient (quo),
		.done     (div_done)
	);

	assign sts.div_done = div_done;

	// Report assembly from the captured fields and the quotient.
	assign loop_st  = f_cue_q ? cue_ls_q : 32'hFFFF_FFFF;
	assign loop_sum = (f_cue_q && f_list_q && mark_q == wavp_pkg::ID_MARK)
		? loop_st + loop_len_q : 32'd0;

	always_comb begin
		r_status = wavp_pkg::RPT_OK;
		r_chan   = '0;
		r_rate   = '0;
		r_width  = '0;
		r_lst    = '0;
		r_count  = '0;
		r_doff   = '0;
		if (!f_riff_q) begin
			r_status = wavp_pkg::RPT_NO_RIFF;
		end else if (!f_fmt_q) begin
			r_status = wavp_pkg::RPT_NO_FMT;
		end else if (fmt_q[15:0] != 16'd1) begin
			r_status = wavp_pkg::RPT_NOT_PCM;
		end else begin
			r_chan  = fmt_q[31:16];
			r_rate  = fmt_q[63:32];
			r_width = width;
			r_lst   = loop_st;
			r_count = loop_sum;
			if (!f_data_q) begin
				r_status = wavp_pkg::RPT_NO_DATA;
			end else begin
				r_doff = 32'(data_start_q) + 32'd8;
				if (width == '0) begin
					r_status = wavp_pkg::RPT_ZERO_WIDTH;
				end else if (loop_sum != '0) begin
					if ($signed(quo) < $signed(loop_sum)) begin
						r_status = wavp_pkg::RPT_BAD_LOOP;
					end
				end else begin
					r_count = quo;
				end
			end
		end
	end

	// Report register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status       <= r_status;
			channels     <= r_chan;
			sample_rate  <= r_rate;
			sample_width <= r_width;
			loop_start   <= r_lst;
			sample_count <= r_count;
			data_offset  <= r_doff;
		end
	end
endmodule

>>> rtl/wavp_ctrl.sv
// Controller: byte acceptance, division sequencing and report handshake.
module wavp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output wavp_pkg::cmd_t cmd,
	input  wavp_pkg::sts_t sts
);
	wavp_pkg::ctrl_state_t state_q, state_n;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wavp_pkg::S_SCAN;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands.
	always_comb begin
		state_n       = state_q;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd.byte_en   = 1'b0;
		cmd.div_start = 1'b0;
		cmd.load      = 1'b0;
		case (state_q)
			wavp_pkg::S_SCAN: begin
				in_ready    = 1'b1;
				cmd.byte_en = in_valid;
				if (in_valid && in_last) begin
					state_n = wavp_pkg::S_START;
				end
			end
			wavp_pkg::S_START: begin
				cmd.div_start = 1'b1;
				state_n       = wavp_pkg::S_DIV;
			end
			wavp_pkg::S_DIV: begin
				if (sts.div_done) begin
					state_n = wavp_pkg::S_LOAD;
				end
			end
			wavp_pkg::S_LOAD: begin
				cmd.load = 1'b1;
				state_n  = wavp_pkg::S_OUT;
			end
			wavp_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_n = wavp_pkg::S_SCAN;
				end
			end
			default: begin
				state_n = wavp_pkg::S_SCAN;
			end
		endcase
	end

	// The final beat of a file starts the report sequence.
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wavp_pkg::S_SCAN && in_valid && in_last) |=> state_q == wavp_pkg::S_START)
		else $error("last beat did not start the report");

	// Division completion leads to the report load.
	a_div_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wavp_pkg::S_DIV && sts.div_done) |=> cmd.load)
		else $error("report not loaded after division");

	// A loaded report is presented in the next cycle.
	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid && !in_ready)
		else $error("report not presented after load");
endmodule

>>> rtl/wav_header_chunk_parser_core.sv
// Top level of the WAV header chunk parser.
// Throughput: one file byte per cycle while scanning.
// After the last beat, the report passes through a start state, the bit-serial
// sample-count divider and a load state before valid is raised.
// No new byte is taken until the report beat is taken.
// Reset (arst_n low) clears the walker and flags; the same clear follows each report.
module wav_header_chunk_parser_core #(
	parameter int OFFSET_BITS = wavp_pkg::OFFSET_BITS_DEF
) (
	input logic    clk,
	input logic    arst_n,
	wavp_byte_if.sink     byte_ch,
	wavp_report_if.source report_ch
);
	wavp_pkg::cmd_t cmd;
	wavp_pkg::sts_t sts;

	wavp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_ch.valid),
		.in_last   (byte_ch.last_byte),
		.in_ready  (byte_ch.ready),
		.out_valid (report_ch.valid),
		.out_ready (report_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	wavp_dpath #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.byte_value   (byte_ch.byte_value),
		.status       (report_ch.status),
		.channels     (report_ch.channels),
		.sample_rate  (report_ch.sample_rate),
		.sample_width (report_ch.sample_width),
		.loop_start   (report_ch.loop_start),
		.sample_count (report_ch.sample_count),
		.data_offset  (report_ch.data_offset)
	);
endmodule

>>> test/wav_header_chunk_parser_core_check.sv
// Report checker for the WAV header chunk parser: predicts each report from the byte stream.
`timescale 1ns / 1ps
module wav_header_chunk_parser_core_check (
	input logic clk,
	input logic arst_n,
	wavp_byte_if byte_ch,
	wavp_report_if report_ch,
	output int fail_count,
	output int report_count,
	output int pending_count
);
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] channels;
		logic [31:0] sample_rate;
		logic [12:0] sample_width;
		logic [31:0] loop_start;
		logic [31:0] sample_count;
		logic [31:0] data_offset;
	} wav_report_t;

	localparam logic [4:0] HAVE_RIFF = 5'd1;
	localparam logic [4:0] HAVE_FMT  = 5'd2;
	localparam logic [4:0] HAVE_CUE  = 5'd4;
	localparam logic [4:0] HAVE_LIST = 5'd8;
	localparam logic [4:0] HAVE_DATA = 5'd16;

	// Shadow copy of the parser state, offsets kept one bit wider than the file offset.
	logic [32:0]       pos_q, riff_at, hdr_at, fmt_at, cue_at, list_at, data_at;
	wavp_pkg::phase_t  phase_q;
	logic [63:0]       shift_q, fmt_word;
	logic [4:0]        have_q;
	logic [15:0]       bits_q;
	logic [31:0]       cue_val, mark_q, loop_len, data_len;

	wav_report_t expected_reports[$];

	task automatic clear_walker();
		pos_q = 0; riff_at = 0; hdr_at = 0; fmt_at = 0; cue_at = 0; list_at = 0;
		data_at = 0; phase_q = wavp_pkg::PH_TOP; shift_q = 0; fmt_word = 0; have_q = 0;
		bits_q = 0; cue_val = 0; mark_q = 0; loop_len = 0; data_len = 0;
	endtask

	task automatic walk_header(input logic [32:0] p);
		logic [31:0] id, len;
		id = shift_q[63:32];
		len = {shift_q[7:0], shift_q[15:8], shift_q[23:16], shift_q[31:24]};
		if (len[31]) begin
			phase_q = wavp_pkg::PH_STOP;
			return;
		end
		if (phase_q == wavp_pkg::PH_TOP) begin
			if (id == wavp_pkg::ID_RIFF) begin
				riff_at = p;
				phase_q = wavp_pkg::PH_WAVE;
				return;
			end
		end else begin
			if (id == wavp_pkg::ID_FMT && !(have_q & HAVE_FMT)) begin
				have_q |= HAVE_FMT; fmt_at = p;
			end else if (id == wavp_pkg::ID_CUE && !(have_q & HAVE_CUE)) begin
				have_q |= HAVE_CUE; cue_at = p;
			end else if (id == wavp_pkg::ID_LIST && (have_q & HAVE_CUE)
				&& !(have_q & HAVE_LIST)) begin
				have_q |= HAVE_LIST; list_at = p;
			end
			if (id == wavp_pkg::ID_DATA && !(have_q & HAVE_DATA)) begin
				have_q |= HAVE_DATA; data_at = p; data_len = len;
			end
		end
		hdr_at = p + 33'd8 + ((33'(len) + 33'd1) & ~33'd1);
	endtask

	task automatic grab_fields(input logic [32:0] p, input logic [7:0] b);
		logic [32:0] d;
		if (have_q & HAVE_FMT) begin
			d = p - fmt_at;
			if (d >= 8 && d <= 15) fmt_word[(d - 8) * 8 +: 8] = b;
			else if (d >= 22 && d <= 23) bits_q[(d - 22) * 8 +: 8] = b;
		end
		if (have_q & HAVE_CUE) begin
			d = p - cue_at;
			if (d >= 32 && d <= 35) cue_val[(d - 32) * 8 +: 8] = b;
		end
		if (have_q & HAVE_LIST) begin
			d = p - list_at;
			if (d >= 24 && d <= 27) loop_len[(d - 24) * 8 +: 8] = b;
			else if (d >= 28 && d <= 31) mark_q = {mark_q[23:0], b};
		end
	endtask

	function automatic wav_report_t build_report();
		wav_report_t r;
		logic [31:0] width, lstart, lsum, samples;
		r = '0;
		lsum = 0;
		if (!(have_q & HAVE_RIFF)) begin r.status = wavp_pkg::RPT_NO_RIFF; return r; end
		if (!(have_q & HAVE_FMT)) begin r.status = wavp_pkg::RPT_NO_FMT; return r; end
		if (fmt_word[15:0] != 16'd1) begin r.status = wavp_pkg::RPT_NOT_PCM; return r; end
		width = 32'(bits_q) / 8;
		r.channels = fmt_word[31:16];
		r.sample_rate = fmt_word[63:32];
		r.sample_width = width[12:0];
		lstart = (have_q & HAVE_CUE) ? cue_val : 32'hFFFFFFFF;
		r.loop_start = lstart;
		if ((have_q & HAVE_CUE) && (have_q & HAVE_LIST) && mark_q == wavp_pkg::ID_MARK)
			lsum = lstart + loop_len;
		r.sample_count = lsum;
		if (!(have_q & HAVE_DATA)) begin r.status = wavp_pkg::RPT_NO_DATA; return r; end
		r.data_offset = data_at[31:0] + 32'd8;
		if (width == 0) begin r.status = wavp_pkg::RPT_ZERO_WIDTH; return r; end
		samples = data_len / width;
		r.status = wavp_pkg::RPT_OK;
		if (lsum != 0) begin
			if ($signed(samples) < $signed(lsum)) r.status = wavp_pkg::RPT_BAD_LOOP;
			return r;
		end
		r.sample_count = samples;
		return r;
	endfunction

	task automatic take_byte(input logic [7:0] b, input logic last);
		logic [32:0] p;
		p = pos_q;
		if (!p[32]) begin
			pos_q = p + 1;
			shift_q = {shift_q[55:0], b};
			grab_fields(p, b);
			if ((phase_q == wavp_pkg::PH_TOP || phase_q == wavp_pkg::PH_SUB)
				&& p == hdr_at + 7)
				walk_header(hdr_at);
			else if (phase_q == wavp_pkg::PH_WAVE && p == riff_at + 11) begin
				if (shift_q[31:0] == wavp_pkg::ID_WAVE) begin
					have_q |= HAVE_RIFF;
					phase_q = wavp_pkg::PH_SUB;
					hdr_at = riff_at + 12;
				end else
					phase_q = wavp_pkg::PH_STOP;
			end
		end
		if (last) begin
			expected_reports.push_back(build_report());
			clear_walker();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch in report %0d: %s got %h want %h", report_count, what, got, want);
		fail_count++;
	endtask

	assign pending_count = expected_reports.size();

	// Sample both channels at the clock edge and compare each report beat.
	always @(posedge clk or negedge arst_n) begin
		wav_report_t w;
		if (!arst_n) begin
			clear_walker();
			expected_reports.delete();
			fail_count <= 0;
			report_count <= 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				take_byte(byte_ch.byte_value, byte_ch.last_byte);
			if (report_ch.valid && report_ch.ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("report beat with no file finished", 32'd1, 32'd0);
				end else begin
					w = expected_reports.pop_front();
					if (report_ch.status != w.status)
						report_mismatch("status", report_ch.status, w.status);
					if (report_ch.channels != w.channels)
						report_mismatch("channels", report_ch.channels, w.channels);
					if (report_ch.sample_rate != w.sample_rate)
						report_mismatch("sample_rate", report_ch.sample_rate, w.sample_rate);
					if (report_ch.sample_width != w.sample_width)
						report_mismatch("sample_width", report_ch.sample_width, w.sample_width);
					if (report_ch.loop_start != w.loop_start)
						report_mismatch("loop_start", report_ch.loop_start, w.loop_start);
					if (report_ch.sample_count != w.sample_count)
						report_mismatch("sample_count", report_ch.sample_count, w.sample_count);
					if (report_ch.data_offset != w.data_offset)
						report_mismatch("data_offset", report_ch.data_offset, w.data_offset);
				end
				report_count++;
			end
		end
	end
endmodule

>>> test/wav_header_chunk_parser_core_test.sv
// Stimulus and verdict for the WAV header chunk parser testbench.
`timescale 1ns / 1ps
module wav_header_chunk_parser_core_test;
	localparam int CYCLE_LIMIT = 400000;
	// Identifier of a chunk that the parser skips.
	localparam logic [31:0] ID_JUNK = 32'h4A554E4B;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, report_count, pending_count;
	int   send_idle_pct = 0, recv_stall_pct = 0;
	bit   hold_off = 0;
	int   cycle_count = 0;
	int   files_sent = 0, bytes_sent = 0;

	wavp_byte_if   byte_ch();
	wavp_report_if report_ch();

	wav_header_chunk_parser_core dut (
		.clk(clk), .arst_n(arst_n), .byte_ch(byte_ch.sink), .report_ch(report_ch.source)
	);

	wav_header_chunk_parser_core_check check (
		.clk(clk), .arst_n(arst_n), .byte_ch(byte_ch), .report_ch(report_ch),
		.fail_count(fail_count), .report_count(report_count),
		.pending_count(pending_count)
	);

	always #6 clk = ~clk;

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			report_ch.ready <= 0;
		else
			report_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	byte unsigned file_buf[$];

	task automatic put_word32(input logic [31:0] v);
		for (int i = 0; i < 4; i++) file_buf.push_back(v[i * 8 +: 8]);
	endtask

	task automatic put_id(input logic [31:0] id);
		for (int i = 3; i >= 0; i--) file_buf.push_back(id[i * 8 +: 8]);
	endtask

	task automatic put_chunk(input logic [31:0] id, input byte unsigned body[$],
		input logic [31:0] len);
		put_id(id);
		put_word32(len);
		foreach (body[i]) file_buf.push_back(body[i]);
		if (len[0] && !len[31]) file_buf.push_back(8'($urandom));
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			2: return 32'h80000000;
			3: return 32'h7FFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	// Send the buffered file, one byte per beat, flagging the final byte.
	task automatic send_file();
		int n;
		n = file_buf.size();
		for (int i = 0; i < n; i++) begin
			while ($urandom_range(99) < send_idle_pct) begin
				byte_ch.valid <= 0;
				@(posedge clk);
			end
			byte_ch.valid <= 1;
			byte_ch.byte_value <= file_buf[i];
			byte_ch.last_byte <= (i == n - 1);
			@(posedge clk);
			while (!byte_ch.ready) @(posedge clk);
			bytes_sent++;
		end
		byte_ch.valid <= 0;
		byte_ch.last_byte <= 0;
		file_buf.delete();
		files_sent++;
	endtask

	// Build a mostly well-formed WAV file with random content and occasional damage.
	task automatic build_file(input int style);
		byte unsigned body[$];
		logic [31:0] len;
		int nsub;
		file_buf.delete();
		if (style == 0) begin
			// Pure noise, sometimes a single byte.
			repeat ($urandom_range(1, 20)) file_buf.push_back(8'($urandom));
			return;
		end
		if ($urandom_range(5) == 0) begin
			body.delete();
			repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
			put_chunk($urandom_range(1) ? wavp_pkg::ID_LIST : ID_JUNK, body, body.size());
		end
		put_id(wavp_pkg::ID_RIFF);
		put_word32($urandom_range(3) == 0 ? pick_word() : 32'd1000);
		put_id($urandom_range(9) == 0 ? pick_word() : wavp_pkg::ID_WAVE);
		nsub = $urandom_range(1, 5);
		for (int k = 0; k < nsub; k++) begin
			body.delete();
			case ($urandom_range(5))
				0, 1: begin
					for (int i = 0; i < 16; i++) body.push_back(8'($urandom));
					body[0] = ($urandom_range(3) != 0) ? 8'd1 : 8'($urandom);
					body[1] = ($urandom_range(3) != 0) ? 8'd0 : 8'($urandom);
					case ($urandom_range(3))
						0: begin body[14] = 8'($urandom_range(7)); body[15] = 0; end
						1: begin body[14] = 8'd16; body[15] = 0; end
						default: ;
					endcase
					body = body[0:$urandom_range(1) ? 15 : $urandom_range(15)];
					put_chunk(wavp_pkg::ID_FMT, body,
						$urandom_range(3) == 0 ? $urandom_range(40) : 16);
				end
				2: begin
					repeat (28) body.push_back(8'($urandom));
					put_chunk(wavp_pkg::ID_CUE, body, $urandom_range(1) ? 28 : $urandom_range(40));
				end
				3: begin
					repeat (16) body.push_back(8'($urandom));
					body.push_back(8'h6D); body.push_back(8'h61);
					body.push_back(8'h72); body.push_back($urandom_range(3) ? 8'h6B : 8'h00);
					put_chunk(wavp_pkg::ID_LIST, body,
						$urandom_range(1) ? 20 : $urandom_range(40));
				end
				4: begin
					len = $urandom_range(3) == 0 ? pick_word() : $urandom_range(64);
					if (len[31] || len > 64) put_chunk(wavp_pkg::ID_DATA, body, len);
					else begin
						repeat (len) body.push_back(8'($urandom));
						put_chunk(wavp_pkg::ID_DATA, body, len);
					end
				end
				default: begin
					len = $urandom_range(7);
					repeat (len) body.push_back(8'($urandom));
					put_chunk($urandom, body, len);
				end
			endcase
		end
		// Occasional truncation.
		if ($urandom_range(7) == 0 && file_buf.size() > 2)
			file_buf = file_buf[0:$urandom_range(file_buf.size() - 1)];
	endtask

	task automatic wait_drained();
		while (pending_count != 0) @(posedge clk);
	endtask

	initial begin
		byte_ch.valid = 0;
		byte_ch.byte_value = 0;
		byte_ch.last_byte = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: one-byte files, then a random structured file and a noise file.
		file_buf.push_back(8'hFF); send_file();
		file_buf.push_back(8'h00); send_file();
		build_file(1); send_file();
		build_file(0); send_file();

		// Random phases with different idle patterns.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 45; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 45; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			while (bytes_sent < (ph + 1) * 420) begin
				build_file($urandom_range(7) != 0);
				if (ph == 2 && files_sent % 7 == 0) begin
					fork
						begin
							hold_off = 1;
							repeat (300) @(posedge clk);
							hold_off = 0;
						end
					join_none
				end
				send_file();
			end
		end

		wait_drained();
		repeat (60) @(posedge clk);
		$display("Sent %0d files (%0d bytes) and checked %0d reports.",
			files_sent, bytes_sent, report_count);
		if (fail_count == 0 && pending_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
